### sv/hfts_pkg.sv
// Shared types, constants and character helpers for the hex float text parser.
// Used by hfts_parser, hfts_pack and hex_float_text_to_single_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hfts_pkg;

    localparam int MANT_W    = 32;
    localparam int SHIFT_W   = 10;
    localparam int EXP_MAG_W = 12;
    localparam int EXP_W     = 14;
    localparam int DIGIT_W   = 4;

    localparam logic signed [SHIFT_W-1:0] FIRST_SHIFT = 10'sd28;
    localparam logic signed [SHIFT_W-1:0] POINT_NONE  = 10'sd32;
    localparam logic signed [SHIFT_W-1:0] SHIFT_MIN   = 10'sh200;
    localparam logic signed [SHIFT_W-1:0] POINT_MAX   = 10'sd511;
    localparam logic signed [SHIFT_W-1:0] DIGIT_STEP  = 10'sd4;

    localparam logic signed [EXP_W-1:0] EXP_OFFSET = 14'sd24;
    localparam logic signed [EXP_W-1:0] BIAS       = 14'sd127;
    localparam logic signed [EXP_W-1:0] BE_MAX     = 14'sd255;

    localparam logic [MANT_W-1:0] TOP_BITS  = 32'he000_0000;
    localparam logic [MANT_W-1:0] ROUND_BIT = 32'h0000_0010;
    localparam logic [MANT_W-1:0] ROUND_ADD = 32'h0000_0020;
    localparam logic [31:0]       INF_BITS  = 32'h7f80_0000;

    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_POINT = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_P  = 8'h50;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_P  = 8'h70;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    typedef enum logic [7:0] {
        PH_START      = 8'b0000_0001,
        PH_AFTER_SIGN = 8'b0000_0010,
        PH_AFTER_ZERO = 8'b0000_0100,
        PH_MANT       = 8'b0000_1000,
        PH_EXP_START  = 8'b0001_0000,
        PH_EXP_DIGITS = 8'b0010_0000,
        PH_DONE       = 8'b0100_0000,
        PH_NOT_HEX    = 8'b1000_0000
    } phase_t;

    // Parse result handed from the parser to the packer.
    typedef struct packed {
        logic                       not_hex;
        logic                       negative;
        logic [MANT_W-1:0]          mant;
        logic signed [SHIFT_W-1:0]  point;
        logic [EXP_MAG_W-1:0]       exp_mag;
        logic                       exp_neg;
    } snap_t;

    // Bit 4 flags a hex digit, bits 3:0 hold its value.
    function automatic logic [DIGIT_W:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                v = c - CH_ZERO;
                hex_digit = {1'b1, v[DIGIT_W-1:0]};
            end else if (c >= CH_LO_A && c <= CH_LO_F) begin
                v = c - CH_LO_A + 8'd10;
                hex_digit = {1'b1, v[DIGIT_W-1:0]};
            end else if (c >= CH_UP_A && c <= CH_UP_F) begin
                v = c - CH_UP_A + 8'd10;
                hex_digit = {1'b1, v[DIGIT_W-1:0]};
            end else begin
                hex_digit = '0;
            end
        end
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

### sv/hfts_parser.sv
// Character parser: phase machine, mantissa and exponent accumulators,
// and the registered parse result handed on at the last character. Uses hfts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hfts_parser #(
    parameter int EXP_SAT = 2047
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  char_accept,
    input  wire [7:0]            char_code,
    input  wire                  last_char,
    input  wire                  snap_ready,
    output logic                 snap_valid,
    output hfts_pkg::snap_t      snap
);

    localparam logic [15:0] EXP_SAT_W = 16'(EXP_SAT);

    hfts_pkg::phase_t                              phase_reg, phase_next;
    logic                                          neg_reg, neg_next;
    logic [hfts_pkg::MANT_W-1:0]                   mant_reg, mant_next;
    logic signed [hfts_pkg::SHIFT_W-1:0]           shift_reg, shift_next;
    logic signed [hfts_pkg::SHIFT_W-1:0]           point_reg, point_next;
    logic                                          seen_reg, seen_next;
    logic [hfts_pkg::EXP_MAG_W-1:0]                mag_reg, mag_next;
    logic                                          eneg_reg, eneg_next;
    logic                                          snap_valid_reg, snap_valid_next;
    hfts_pkg::snap_t                               snap_reg, snap_next;

    logic [hfts_pkg::DIGIT_W:0]                    hex;
    logic [hfts_pkg::DIGIT_W-1:0]                  digit;
    logic signed [hfts_pkg::SHIFT_W:0]             point_up;
    logic [15:0]                                   mag_acc;
    logic [7:0]                                    dec_val;

    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mant_next  = mant_reg;
        shift_next = shift_reg;
        point_next = point_reg;
        seen_next  = seen_reg;
        mag_next   = mag_reg;
        eneg_next  = eneg_reg;

        hex      = hfts_pkg::hex_digit(char_code);
        digit    = hex[hfts_pkg::DIGIT_W-1:0];
        point_up = {point_reg[hfts_pkg::SHIFT_W-1], point_reg}
                   + {{(hfts_pkg::SHIFT_W-3){1'b0}}, 4'sd4};
        dec_val  = char_code - hfts_pkg::CH_ZERO;
        mag_acc  = 16'(mag_reg) * 16'd10 + {12'd0, dec_val[3:0]};

        unique case (phase_reg)
            hfts_pkg::PH_START: begin
                if (char_code == hfts_pkg::CH_MINUS || char_code == hfts_pkg::CH_PLUS) begin
                    neg_next   = (char_code == hfts_pkg::CH_MINUS);
                    phase_next = hfts_pkg::PH_AFTER_SIGN;
                end else if (char_code == hfts_pkg::CH_ZERO) begin
                    phase_next = hfts_pkg::PH_AFTER_ZERO;
                end else begin
                    phase_next = hfts_pkg::PH_NOT_HEX;
                end
            end
            hfts_pkg::PH_AFTER_SIGN: begin
                phase_next = (char_code == hfts_pkg::CH_ZERO) ? hfts_pkg::PH_AFTER_ZERO
                                                              : hfts_pkg::PH_NOT_HEX;
            end
            hfts_pkg::PH_AFTER_ZERO: begin
                phase_next = (char_code == hfts_pkg::CH_LO_X || char_code == hfts_pkg::CH_UP_X)
                             ? hfts_pkg::PH_MANT : hfts_pkg::PH_NOT_HEX;
            end
            hfts_pkg::PH_MANT: begin
                if (hex[hfts_pkg::DIGIT_W]) begin
                    // Leading zeros are dropped; past the point they still scale the value.
                    if (digit == '0 && shift_reg == hfts_pkg::FIRST_SHIFT) begin
                        if (seen_reg) begin
                            point_next = (point_up > 11'sd511) ? hfts_pkg::POINT_MAX
                                                               : point_up[hfts_pkg::SHIFT_W-1:0];
                        end
                    end else begin
                        if (!shift_reg[hfts_pkg::SHIFT_W-1]) begin
                            mant_next = mant_reg
                                        | ({28'd0, digit} << shift_reg[4:0]);
                        end
                        if (shift_reg != hfts_pkg::SHIFT_MIN) begin
                            shift_next = shift_reg - hfts_pkg::DIGIT_STEP;
                        end
                    end
                end else if (char_code == hfts_pkg::CH_POINT) begin
                    point_next = shift_reg;
                    seen_next  = 1'b1;
                end else if (char_code == hfts_pkg::CH_LO_P || char_code == hfts_pkg::CH_UP_P) begin
                    phase_next = hfts_pkg::PH_EXP_START;
                end else begin
                    phase_next = hfts_pkg::PH_DONE;
                end
            end
            hfts_pkg::PH_EXP_START: begin
                if (hfts_pkg::is_blank(char_code)) begin
                    phase_next = hfts_pkg::PH_EXP_START;
                end else if (char_code == hfts_pkg::CH_MINUS || char_code == hfts_pkg::CH_PLUS) begin
                    eneg_next  = (char_code == hfts_pkg::CH_MINUS);
                    phase_next = hfts_pkg::PH_EXP_DIGITS;
                end else if (hfts_pkg::is_dec(char_code)) begin
                    mag_next   = (mag_acc > EXP_SAT_W) ? EXP_SAT_W[hfts_pkg::EXP_MAG_W-1:0]
                                                       : mag_acc[hfts_pkg::EXP_MAG_W-1:0];
                    phase_next = hfts_pkg::PH_EXP_DIGITS;
                end else begin
                    phase_next = hfts_pkg::PH_DONE;
                end
            end
            hfts_pkg::PH_EXP_DIGITS: begin
                if (hfts_pkg::is_dec(char_code)) begin
                    mag_next = (mag_acc > EXP_SAT_W) ? EXP_SAT_W[hfts_pkg::EXP_MAG_W-1:0]
                                                     : mag_acc[hfts_pkg::EXP_MAG_W-1:0];
                end else begin
                    phase_next = hfts_pkg::PH_DONE;
                end
            end
            hfts_pkg::PH_DONE, hfts_pkg::PH_NOT_HEX: begin
                phase_next = phase_reg;
            end
            default: begin
                phase_next = hfts_pkg::PH_DONE;
            end
        endcase

        snap_next.not_hex  = (phase_next == hfts_pkg::PH_START)
                          || (phase_next == hfts_pkg::PH_AFTER_SIGN)
                          || (phase_next == hfts_pkg::PH_AFTER_ZERO)
                          || (phase_next == hfts_pkg::PH_NOT_HEX);
        snap_next.negative = neg_next;
        snap_next.mant     = mant_next;
        snap_next.point    = seen_next ? point_next : shift_next;
        snap_next.exp_mag  = mag_next;
        snap_next.exp_neg  = eneg_next;

        if (char_accept && last_char) begin
            snap_valid_next = 1'b1;
        end else if (snap_ready) begin
            snap_valid_next = 1'b0;
        end else begin
            snap_valid_next = snap_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= hfts_pkg::PH_START;
            neg_reg        <= 1'b0;
            mant_reg       <= '0;
            shift_reg      <= hfts_pkg::FIRST_SHIFT;
            point_reg      <= hfts_pkg::POINT_NONE;
            seen_reg       <= 1'b0;
            mag_reg        <= '0;
            eneg_reg       <= 1'b0;
            snap_valid_reg <= 1'b0;
        end else begin
            snap_valid_reg <= snap_valid_next;
            if (char_accept) begin
                if (last_char) begin
                    // The string is finished: start over for the next literal.
                    phase_reg <= hfts_pkg::PH_START;
                    neg_reg   <= 1'b0;
                    mant_reg  <= '0;
                    shift_reg <= hfts_pkg::FIRST_SHIFT;
                    point_reg <= hfts_pkg::POINT_NONE;
                    seen_reg  <= 1'b0;
                    mag_reg   <= '0;
                    eneg_reg  <= 1'b0;
                end else begin
                    phase_reg <= phase_next;
                    neg_reg   <= neg_next;
                    mant_reg  <= mant_next;
                    shift_reg <= shift_next;
                    point_reg <= point_next;
                    seen_reg  <= seen_next;
                    mag_reg   <= mag_next;
                    eneg_reg  <= eneg_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (char_accept && last_char) begin
            snap_reg <= snap_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

`ifndef NO_ASSERTIONS
    // The first kept digit always lands in the top nibble.
    a_mant_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (mant_reg != '0) |-> (mant_reg[31:28] != 4'd0))
        else $error("mantissa accumulator lost its leading digit");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (char_accept && last_char) |=> (phase_reg == hfts_pkg::PH_START && snap_valid_reg))
        else $error("parser did not restart after the last character");
`endif

endmodule

`default_nettype wire

### sv/hfts_pack.sv
// Normalize, round and pack one parse result into IEEE single bits,
// held in the output register. Uses hfts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hfts_pack (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  snap_valid,
    input  hfts_pkg::snap_t      snap,
    output logic                 snap_ready,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [39:0]          m_tdata    // value_bits[31:0], not_hex, out_of_range, zero pad
);

    logic                                 out_valid_reg, out_valid_next;
    logic [31:0]                          value_reg, value_next;
    logic                                 nothex_reg, nothex_next;
    logic                                 oor_reg, oor_next;

    logic [hfts_pkg::MANT_W-1:0]          norm_bits;
    logic [hfts_pkg::MANT_W-1:0]          rnd_bits;
    logic [hfts_pkg::MANT_W-1:0]          fin_bits;
    logic signed [hfts_pkg::EXP_W-1:0]    norm_shift;
    logic signed [hfts_pkg::EXP_W-1:0]    rnd_shift;
    logic signed [hfts_pkg::EXP_W-1:0]    exp_s;
    logic signed [hfts_pkg::EXP_W-1:0]    be;
    logic [31:0]                          sign_bit;

    always_comb begin
        // Bring the leading one down to bit 28.
        if (snap.mant[31]) begin
            norm_bits  = snap.mant >> 3;
            norm_shift = 14'sd3;
        end else if (snap.mant[30]) begin
            norm_bits  = snap.mant >> 2;
            norm_shift = 14'sd2;
        end else if (snap.mant[29]) begin
            norm_bits  = snap.mant >> 1;
            norm_shift = 14'sd1;
        end else begin
            norm_bits  = snap.mant;
            norm_shift = 14'sd0;
        end

        rnd_bits  = ((norm_bits & hfts_pkg::ROUND_BIT) != '0) ? norm_bits + hfts_pkg::ROUND_ADD
                                                               : norm_bits;
        if ((rnd_bits & hfts_pkg::TOP_BITS) != '0) begin
            fin_bits  = rnd_bits >> 1;
            rnd_shift = 14'sd1;
        end else begin
            fin_bits  = rnd_bits;
            rnd_shift = 14'sd0;
        end

        exp_s = snap.exp_neg ? -$signed({2'b00, snap.exp_mag}) : $signed({2'b00, snap.exp_mag});
        be    = exp_s - {{(hfts_pkg::EXP_W-hfts_pkg::SHIFT_W){snap.point[hfts_pkg::SHIFT_W-1]}},
                         snap.point}
                + hfts_pkg::EXP_OFFSET + hfts_pkg::BIAS + norm_shift + rnd_shift;

        sign_bit    = {snap.negative, 31'd0};
        nothex_next = snap.not_hex;
        oor_next    = 1'b0;
        value_next  = 32'd0;
        if (!snap.not_hex && snap.mant != '0) begin
            if (be >= hfts_pkg::BE_MAX) begin
                value_next = sign_bit | hfts_pkg::INF_BITS;
                oor_next   = 1'b1;
            end else if (be <= 14'sd0) begin
                value_next = sign_bit;
                oor_next   = 1'b1;
            end else begin
                value_next = sign_bit | {1'b0, be[7:0], fin_bits[27:5]};
            end
        end

        if (snap_valid && snap_ready) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign snap_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_valid && snap_ready) begin
            value_reg  <= value_next;
            nothex_reg <= nothex_next;
            oor_reg    <= oor_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, oor_reg, nothex_reg, value_reg};

`ifndef NO_ASSERTIONS
    a_nothex_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && nothex_reg) |-> (value_reg == 32'd0 && !oor_reg))
        else $error("text without a prefix produced a nonzero word");

    a_oor_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && oor_reg) |->
            (value_reg[30:0] == hfts_pkg::INF_BITS[30:0] || value_reg[30:0] == 31'd0))
        else $error("out of range word is neither infinity nor zero");
`endif

endmodule

`default_nettype wire

### sv/hex_float_text_to_single_core.sv
// Top level: hex float text to IEEE single converter built from hfts_parser
// and hfts_pack. Uses hfts_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one character word per clock on the s_ stream unless the output
// stalls, s_tlast marking the final character of a literal such as -0x1.8p3.
// Every character is consumed in the cycle it is accepted by the parser's phase
// machine and accumulators; the final character also loads a result register,
// and the pack stage turns that into a single-precision word in the output
// register, which drives m_. Literals may follow each other with no gap while
// the output is not stalled. Exponent digits saturate at EXP_SAT.
module hex_float_text_to_single_core #(
    parameter int EXP_SAT = 2047
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [7:0]   s_tdata,   // char_code[7:0]
    input  wire          s_tlast,   // last_char
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [39:0]  m_tdata    // value_bits[31:0], not_hex, out_of_range, zero pad
);

    logic            char_accept;
    logic            snap_valid;
    logic            snap_ready;
    hfts_pkg::snap_t snap;

    assign s_tready    = !snap_valid || snap_ready;
    assign char_accept = s_tvalid && s_tready;

    hfts_parser #(
        .EXP_SAT (EXP_SAT)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .char_accept (char_accept),
        .char_code   (s_tdata),
        .last_char   (s_tlast),
        .snap_ready  (snap_ready),
        .snap_valid  (snap_valid),
        .snap        (snap)
    );

    hfts_pack u_pack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

### test/hex_float_text_to_single_core_tb.sv
// Self-checking bench for hex_float_text_to_single_core: streams hex float
// literals one character word at a time and checks every packed single result.
// Depends on hfts_pkg and the core RTL only.
`timescale 1ns / 1ps

module hex_float_text_to_single_core_tb;

    localparam int EXP_SAT        = 2047;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_CHARS   = 750;

    typedef struct packed {
        logic [31:0] value;
        logic        not_hex;
        logic        out_of_range;
    } float_word_t;

    // Tracks the parse of the literal in flight and queues the single that
    // each final character should produce.
    class hexfloat_scoreboard;
        hfts_pkg::phase_t phase;
        logic        negative;
        logic [31:0] mant;
        int          shift;
        int          point_pos;
        logic        point_seen;
        int          exp_mag;
        logic        exp_neg;
        int          exp_sat;
        float_word_t expected_q[$];
        int          errors;
        int          results;
        int          not_hex_cnt;
        int          range_cnt;

        function new(int sat);
            exp_sat     = sat;
            errors      = 0;
            results     = 0;
            not_hex_cnt = 0;
            range_cnt   = 0;
            clear_literal();
        endfunction

        function void clear_literal();
            phase      = hfts_pkg::PH_START;
            negative   = 1'b0;
            mant       = '0;
            shift      = hfts_pkg::FIRST_SHIFT;
            point_pos  = hfts_pkg::POINT_NONE;
            point_seen = 1'b0;
            exp_mag    = 0;
            exp_neg    = 1'b0;
        endfunction

        function int digit_of(logic [7:0] c);
            if (c >= hfts_pkg::CH_ZERO && c <= hfts_pkg::CH_NINE)
                return int'(c - hfts_pkg::CH_ZERO);
            if (c >= hfts_pkg::CH_LO_A && c <= hfts_pkg::CH_LO_F)
                return int'(c - hfts_pkg::CH_LO_A) + 10;
            if (c >= hfts_pkg::CH_UP_A && c <= hfts_pkg::CH_UP_F)
                return int'(c - hfts_pkg::CH_UP_A) + 10;
            return -1;
        endfunction

        function void add_exp_digit(logic [7:0] c);
            exp_mag = exp_mag * 10 + int'(c - hfts_pkg::CH_ZERO);
            if (exp_mag > exp_sat) exp_mag = exp_sat;
        endfunction

        function float_word_t pack_value();
            float_word_t r;
            int          pt;
            int          e;
            int          be;
            logic [31:0] bits;
            logic [31:0] sign;
            r = '0;
            if (phase == hfts_pkg::PH_START || phase == hfts_pkg::PH_AFTER_SIGN ||
                phase == hfts_pkg::PH_AFTER_ZERO || phase == hfts_pkg::PH_NOT_HEX) begin
                r.not_hex = 1'b1;
            end else if (mant != 0) begin
                pt   = point_seen ? point_pos : shift;
                e    = (exp_neg ? -exp_mag : exp_mag) - pt + int'(hfts_pkg::EXP_OFFSET);
                bits = mant;
                sign = negative ? 32'h8000_0000 : 32'h0;
                while ((bits & hfts_pkg::TOP_BITS) != 0) begin
                    bits = bits >> 1;
                    e++;
                end
                // Rounding can carry into the top bits, which costs one more shift.
                if ((bits & hfts_pkg::ROUND_BIT) != 0) begin
                    bits = bits + hfts_pkg::ROUND_ADD;
                    if ((bits & hfts_pkg::TOP_BITS) != 0) begin
                        bits = bits >> 1;
                        e++;
                    end
                end
                be = e + int'(hfts_pkg::BIAS);
                if (be >= int'(hfts_pkg::BE_MAX)) begin
                    r.value        = sign | hfts_pkg::INF_BITS;
                    r.out_of_range = 1'b1;
                end else if (be <= 0) begin
                    r.value        = sign;
                    r.out_of_range = 1'b1;
                end else begin
                    r.value = sign | (32'(be) << 23) | ((bits >> 5) & 32'h007f_ffff);
                end
            end
            return r;
        endfunction

        function void note_char(logic [7:0] c, logic last);
            int d;
            d = digit_of(c);
            case (phase)
                hfts_pkg::PH_START: begin
                    if (c == hfts_pkg::CH_MINUS || c == hfts_pkg::CH_PLUS) begin
                        negative = (c == hfts_pkg::CH_MINUS);
                        phase    = hfts_pkg::PH_AFTER_SIGN;
                    end else begin
                        phase = (c == hfts_pkg::CH_ZERO) ? hfts_pkg::PH_AFTER_ZERO
                                                         : hfts_pkg::PH_NOT_HEX;
                    end
                end
                hfts_pkg::PH_AFTER_SIGN: begin
                    phase = (c == hfts_pkg::CH_ZERO) ? hfts_pkg::PH_AFTER_ZERO
                                                     : hfts_pkg::PH_NOT_HEX;
                end
                hfts_pkg::PH_AFTER_ZERO: begin
                    phase = (c == hfts_pkg::CH_LO_X || c == hfts_pkg::CH_UP_X)
                            ? hfts_pkg::PH_MANT : hfts_pkg::PH_NOT_HEX;
                end
                hfts_pkg::PH_MANT: begin
                    if (d >= 0) begin
                        // Zeros ahead of the first significant digit only matter
                        // once a point has been seen.
                        if (d == 0 && shift == hfts_pkg::FIRST_SHIFT) begin
                            if (point_seen)
                                point_pos = (point_pos + 4 > hfts_pkg::POINT_MAX)
                                            ? hfts_pkg::POINT_MAX : point_pos + 4;
                        end else begin
                            if (shift >= 0) mant = mant | (32'(d) << shift);
                            if (shift > hfts_pkg::SHIFT_MIN) shift = shift - 4;
                        end
                    end else if (c == hfts_pkg::CH_POINT) begin
                        point_pos  = shift;
                        point_seen = 1'b1;
                    end else if (c == hfts_pkg::CH_LO_P || c == hfts_pkg::CH_UP_P) begin
                        phase = hfts_pkg::PH_EXP_START;
                    end else begin
                        phase = hfts_pkg::PH_DONE;
                    end
                end
                hfts_pkg::PH_EXP_START: begin
                    if (c == hfts_pkg::CH_SPACE ||
                        (c >= hfts_pkg::CH_TAB && c <= hfts_pkg::CH_CR)) begin
                        phase = hfts_pkg::PH_EXP_START;
                    end else if (c == hfts_pkg::CH_MINUS || c == hfts_pkg::CH_PLUS) begin
                        exp_neg = (c == hfts_pkg::CH_MINUS);
                        phase   = hfts_pkg::PH_EXP_DIGITS;
                    end else if (c >= hfts_pkg::CH_ZERO && c <= hfts_pkg::CH_NINE) begin
                        add_exp_digit(c);
                        phase = hfts_pkg::PH_EXP_DIGITS;
                    end else begin
                        phase = hfts_pkg::PH_DONE;
                    end
                end
                hfts_pkg::PH_EXP_DIGITS: begin
                    if (c >= hfts_pkg::CH_ZERO && c <= hfts_pkg::CH_NINE) add_exp_digit(c);
                    else phase = hfts_pkg::PH_DONE;
                end
                default: ;
            endcase
            if (last) begin
                expected_q.insert(expected_q.size(), pack_value());
                clear_literal();
            end
        endfunction

        function void check_result(logic [39:0] word);
            float_word_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result word %h arrived with nothing expected", $time, word);
                return;
            end
            want = expected_q.pop_front();
            results++;
            if (want.not_hex) not_hex_cnt++;
            if (want.out_of_range) range_cnt++;
            if (word[31:0] !== want.value) begin
                errors++;
                $display("%0t: value_bits expected %h actual %h", $time, want.value, word[31:0]);
            end
            if (word[32] !== want.not_hex) begin
                errors++;
                $display("%0t: not_hex expected %b actual %b", $time, want.not_hex, word[32]);
            end
            if (word[33] !== want.out_of_range) begin
                errors++;
                $display("%0t: out_of_range expected %b actual %b", $time,
                         want.out_of_range, word[33]);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [39:0] m_tdata;

    hexfloat_scoreboard sb;
    logic [7:0] text_q[$];
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int chars_sent     = 0;
    int literals       = 0;
    int quiet_cycles   = 0;

    hex_float_text_to_single_core #(
        .EXP_SAT (EXP_SAT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] hex_char(int v);
        if (v < 10) return hfts_pkg::CH_ZERO + 8'(v);
        return ($urandom_range(1) ? hfts_pkg::CH_LO_A : hfts_pkg::CH_UP_A) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] blank_char();
        int k = $urandom_range(5);
        return (k == 5) ? hfts_pkg::CH_SPACE : hfts_pkg::CH_TAB + 8'(k);
    endfunction

    function automatic void queue_char(logic [7:0] c);
        text_q.insert(text_q.size(), c);
    endfunction

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++) queue_char(s[i]);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_char(c, last);
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic send_literal();
        for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
        text_q.delete();
        literals++;
    endtask

    // Mostly well-formed literals with random content; a few are pure noise or
    // have a broken prefix. The long kinds push the digit and point counters
    // into saturation.
    task automatic build_literal(input int long_kind);
        int pick;
        int n_lead;
        int n_dig;
        int point_at;
        int exp_val;
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 6)) queue_char(8'($urandom_range(255)));
            return;
        end
        pick = $urandom_range(99);
        if (pick < 30) queue_char(hfts_pkg::CH_MINUS);
        else if (pick < 45) queue_char(hfts_pkg::CH_PLUS);
        if ($urandom_range(99) < 6) begin
            if ($urandom_range(1)) queue_char(hfts_pkg::CH_ZERO);
            queue_char(8'($urandom_range(255)));
        end else begin
            queue_char(hfts_pkg::CH_ZERO);
            queue_char($urandom_range(1) ? hfts_pkg::CH_LO_X : hfts_pkg::CH_UP_X);
        end
        n_lead = ($urandom_range(99) < 40) ? $urandom_range(1, 3) : 0;
        n_dig  = (long_kind == 1) ? 140 : $urandom_range(0, 10);
        if (long_kind == 2) begin
            n_lead   = 130;
            point_at = 0;
        end else begin
            point_at = ($urandom_range(99) < 55) ? $urandom_range(0, n_lead + n_dig) : -1;
        end
        for (int i = 0; i <= n_lead + n_dig; i++) begin
            if (i == point_at || $urandom_range(99) < 3) queue_char(hfts_pkg::CH_POINT);
            if (i < n_lead) queue_char(hfts_pkg::CH_ZERO);
            else if (i < n_lead + n_dig) queue_char(hex_char($urandom_range(15)));
        end
        if ($urandom_range(99) < 75) begin
            queue_char($urandom_range(1) ? hfts_pkg::CH_LO_P : hfts_pkg::CH_UP_P);
            if ($urandom_range(99) < 15) repeat ($urandom_range(1, 2)) queue_char(blank_char());
            pick = $urandom_range(99);
            if (pick < 35) queue_char(hfts_pkg::CH_MINUS);
            else if (pick < 55) queue_char(hfts_pkg::CH_PLUS);
            pick = $urandom_range(99);
            if (pick < 55) exp_val = $urandom_range(0, 40);
            else if (pick < 75) exp_val = $urandom_range(41, 200);
            else if (pick < 92) exp_val = $urandom_range(201, 999);
            else exp_val = $urandom_range(1000, 99999);
            if ($urandom_range(99) >= 5) add_str($sformatf("%0d", exp_val));
        end
        if ($urandom_range(99) < 30) repeat ($urandom_range(1, 3))
            queue_char(8'($urandom_range(255)));
    endtask

    initial begin
        sb = new(EXP_SAT);
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed literals: sign, point and exponent together; zero mantissa;
        // zeros after the point with a repeated point and a blank before the
        // exponent sign; a bare p; overflow with a saturated exponent; underflow
        // to signed zero; missing prefixes with the byte extremes.
        add_str("-0xA.8p3");
        send_literal();
        add_str("0X0");
        send_literal();
        add_str("+0x.0f.P\t-2");
        send_literal();
        add_str("0x1p");
        send_literal();
        add_str("0xfffffffffp9999");
        send_literal();
        add_str("-0x1p-150");
        send_literal();
        queue_char(hfts_pkg::CH_ZERO);
        queue_char(8'hff);
        send_literal();
        queue_char(8'h00);
        send_literal();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 55; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 55; end
                default: begin src_idle_pct = 14; sink_stall_pct = 14; end
            endcase
            while (chars_sent < 54 + (ph + 1) * (RANDOM_CHARS / 4)) begin
                build_literal((literals == 14) ? 1 : (literals == 33) ? 2 : 0);
                send_literal();
            end
        end
        s_tvalid <= 1'b0;
        sink_stall_pct = 0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);

        $display("Streamed %0d literals in %0d characters across four idle and stall mixes.",
                 literals, chars_sent);
        $display("Checked %0d singles: %0d without prefix, %0d out of range, %0d mismatches.",
                 sb.results, sb.not_hex_cnt, sb.range_cnt, sb.errors);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
